FILE: rtl/ssot_pkg.sv
package ssot_pkg;

    // coordinate and axis formats
    localparam int COORD_BITS         = 16;
    localparam int AXIS_FRACTION_BITS = 14;
    localparam int AXIS_COMP_BITS     = 16;

    // derived datapath widths
    localparam int WB   = COORD_BITS + 1;                    // centre difference
    localparam int PB   = WB + AXIS_COMP_BITS;               // one dot-product term
    localparam int DB   = PB + 2;                            // dot product
    localparam int WSQB = 2 * WB;                            // squared difference term
    localparam int WWB  = WSQB + 2;                          // |w|^2
    localparam int USQB = 2 * AXIS_COMP_BITS;                // squared axis term
    localparam int UUB  = USQB + 2;                          // |u|^2
    localparam int EB   = COORD_BITS + AXIS_FRACTION_BITS + 1;
    localparam int XB   = ((DB > EB) ? DB : EB) + 1;         // box excess
    localparam int RSB  = COORD_BITS + 1;                    // summed radii
    localparam int R2B  = 2 * RSB;
    localparam int SRQB = 2 * COORD_BITS;                    // sphere radius squared
    localparam int HUB  = COORD_BITS + UUB;                  // h * |u|^2
    localparam int UHB  = AXIS_COMP_BITS + COORD_BITS + 1;   // u * h
    localparam int DDB  = (((WB + AXIS_FRACTION_BITS) > UHB) ?
                           (WB + AXIS_FRACTION_BITS) : UHB) + 1;
    localparam int CW   = (((DB + AXIS_FRACTION_BITS) > (HUB + 1)) ?
                           (DB + AXIS_FRACTION_BITS) : (HUB + 1)) + 1;

    typedef enum logic [1:0] {
        MODE_BOX     = 2'd0,
        MODE_SPHERE  = 2'd1,
        MODE_CAPSULE = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

endpackage

FILE: rtl/sphere_shape_overlap_test.sv
// Sphere overlap test: each request carries a sphere and one other shape (oriented box,
// sphere or capsule, picked by s_mode; mode none always answers no overlap) and yields
// one m_overlap bit, 1 when the shapes touch or intersect. All comparisons use exact wide
// integer products, so nothing rounds. The block is a seven-stage pipeline: a request is
// taken every cycle while the output side keeps taking results, and its answer is held in
// the output register until read. The whole pipeline advances together whenever the output
// register is empty or being read, so a stall on m_ready holds every stage in place and
// s_ready follows m_ready combinationally. The block keeps no state between requests.
module sphere_shape_overlap_test (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic [1:0]                                 s_mode,
    input  logic [3*ssot_pkg::COORD_BITS-1:0]          s_sphere_center,
    input  logic [ssot_pkg::COORD_BITS-1:0]            s_sphere_radius,
    input  logic [3*ssot_pkg::COORD_BITS-1:0]          s_other_center,
    input  logic [3*ssot_pkg::COORD_BITS-1:0]          s_other_size,
    input  logic [3*ssot_pkg::AXIS_COMP_BITS-1:0]      s_axis_x,
    input  logic [3*ssot_pkg::AXIS_COMP_BITS-1:0]      s_axis_y,
    input  logic [3*ssot_pkg::AXIS_COMP_BITS-1:0]      s_axis_z,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic                                       m_overlap
);
    import ssot_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int AB  = AXIS_COMP_BITS;
    localparam int AFB = AXIS_FRACTION_BITS;

    // pipeline control: one enable for all stages
    logic       adv;
    logic [6:1] vld_reg;
    logic       m_valid_reg;
    logic       m_overlap_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_overlap = m_overlap_reg;

    logic [3*AB-1:0] axis_in [3];
    assign axis_in[0] = s_axis_x;
    assign axis_in[1] = s_axis_y;
    assign axis_in[2] = s_axis_z;

    // stage 1: unpack, centre difference
    mode_t                  mode1_reg;
    logic signed [WB-1:0]   w1_reg  [3];
    logic signed [AB-1:0]   ax1_reg [3][3];
    logic [CB-1:0]          sz1_reg [3];
    logic [CB-1:0]          sr1_reg;

    // stage 2: all narrow products
    mode_t                  mode2_reg;
    logic signed [WB-1:0]   w2_reg  [3];
    logic signed [AB-1:0]   u2_reg  [3];
    logic [CB-1:0]          sz2_reg [3];
    logic [CB-1:0]          sr2_reg;
    logic [RSB-1:0]         rs2_reg;
    logic signed [PB-1:0]   prod2_reg [3][3];
    logic [WSQB-1:0]        wsq2_reg [3];
    logic [USQB-1:0]        usq2_reg [3];

    // stage 3: dot products and squared lengths
    mode_t                  mode3_reg;
    logic signed [WB-1:0]   w3_reg  [3];
    logic signed [AB-1:0]   u3_reg  [3];
    logic [CB-1:0]          sz3_reg [3];
    logic [CB-1:0]          sr3_reg;
    logic [RSB-1:0]         rs3_reg;
    logic signed [DB-1:0]   p3_reg  [3];
    logic [WWB-1:0]         ww3_reg;
    logic [UUB-1:0]         uu3_reg;

    // stage 4: box excess, capsule scale terms
    mode_t                  mode4_reg;
    logic signed [WB-1:0]   w4_reg  [3];
    logic [XB-1:0]          ex4_reg [3];
    logic [HUB-1:0]         hu4_reg;
    logic [R2B-1:0]         r2_4_reg;
    logic signed [UHB-1:0]  uh4_reg [3];
    logic [SRQB-1:0]        srq4_reg;
    logic signed [DB-1:0]   s4_reg;
    logic [WWB-1:0]         ww4_reg;
    logic [UUB-1:0]         uu4_reg;
    logic                   pt4_reg;

    // stage 5: squares of excess, capsule region select and wide products
    mode_t                  mode5_reg;
    logic [2*XB-1:0]        exsq5_reg [3];
    logic [SRQB-1:0]        srq5_reg;
    logic                   end5_reg;
    logic signed [DDB-1:0]  dd5_reg [3];
    logic [WWB+UUB-1:0]     wwuu5_reg;
    logic [R2B+UUB-1:0]     r2uu5_reg;
    logic [2*DB-1:0]        ssq5_reg;
    logic                   near5_reg;
    logic                   pt5_reg;
    logic [R2B-1:0]         r2_5_reg;

    // stage 6: box and capsule-side compares, squared end-point distance terms
    mode_t                  mode6_reg;
    logic                   boxhit6_reg;
    logic                   midhit6_reg;
    logic [2*DDB-1:0]       dsq6_reg [3];
    logic                   end6_reg;
    logic                   pt6_reg;
    logic                   near6_reg;
    logic [R2B-1:0]         r2_6_reg;

    // stage 4 combinational: clamp excess of projection beyond box extent
    logic [XB-1:0] ex_next [3];
    always_comb begin
        logic signed [XB-1:0] pe;
        logic signed [XB-1:0] ee;
        for (int k = 0; k < 3; k++) begin
            pe = XB'(p3_reg[k]);
            ee = signed'(XB'(sz3_reg[k]) << AFB);
            if (pe > ee) begin
                ex_next[k] = unsigned'(pe - ee);
            end else if (pe < -ee) begin
                ex_next[k] = unsigned'(-ee - pe);
            end else begin
                ex_next[k] = '0;
            end
        end
    end

    // stage 5 combinational: capsule segment end test and end-point offset
    logic signed [CW-1:0]  sa_c;
    logic signed [CW-1:0]  hu_c;
    logic                  cap_pos;
    logic                  cap_end;
    logic signed [DDB-1:0] dd_next [3];
    always_comb begin
        sa_c    = CW'(s4_reg) <<< AFB;
        hu_c    = signed'(CW'(hu4_reg));
        cap_pos = sa_c >= hu_c;
        cap_end = cap_pos || (sa_c <= -hu_c);
        for (int i = 0; i < 3; i++) begin
            if (cap_pos) begin
                dd_next[i] = (DDB'(w4_reg[i]) <<< AFB) - DDB'(uh4_reg[i]);
            end else begin
                dd_next[i] = (DDB'(w4_reg[i]) <<< AFB) + DDB'(uh4_reg[i]);
            end
        end
    end

    // stage 7 combinational: final compare and mode select
    logic [2*DDB+1:0] dsum_c;
    logic             cap_hit;
    logic             hit_next;
    always_comb begin
        dsum_c = (2*DDB+2)'(dsq6_reg[0]) + (2*DDB+2)'(dsq6_reg[1])
               + (2*DDB+2)'(dsq6_reg[2]);
        if (pt6_reg) begin
            cap_hit = near6_reg;
        end else if (end6_reg) begin
            cap_hit = dsum_c <= ((R2B+2*AFB)'(r2_6_reg) << (2*AFB));
        end else begin
            cap_hit = midhit6_reg;
        end
        unique case (mode6_reg)
            MODE_BOX:     hit_next = boxhit6_reg;
            MODE_SPHERE:  hit_next = near6_reg;
            MODE_CAPSULE: hit_next = cap_hit;
            MODE_NONE:    hit_next = 1'b0;
            default:      hit_next = 1'b0;
        endcase
    end

    // valid bits, the only reset state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[5:1], s_valid};
            m_valid_reg <= vld_reg[6];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            mode1_reg <= mode_t'(s_mode);
            sr1_reg   <= s_sphere_radius;
            for (int i = 0; i < 3; i++) begin
                w1_reg[i]  <= WB'(signed'(s_sphere_center[i*CB +: CB]))
                            - WB'(signed'(s_other_center[i*CB +: CB]));
                sz1_reg[i] <= s_other_size[i*CB +: CB];
                for (int k = 0; k < 3; k++) begin
                    ax1_reg[k][i] <= signed'(axis_in[k][i*AB +: AB]);
                end
            end

            // stage 2
            mode2_reg <= mode1_reg;
            sr2_reg   <= sr1_reg;
            rs2_reg   <= RSB'(sr1_reg)
                       + RSB'((mode1_reg == MODE_SPHERE) ? sz1_reg[0] : sz1_reg[1]);
            for (int i = 0; i < 3; i++) begin
                w2_reg[i]   <= w1_reg[i];
                u2_reg[i]   <= ax1_reg[1][i];
                sz2_reg[i]  <= sz1_reg[i];
                wsq2_reg[i] <= unsigned'(WSQB'(w1_reg[i]) * WSQB'(w1_reg[i]));
                usq2_reg[i] <= unsigned'(USQB'(ax1_reg[1][i]) * USQB'(ax1_reg[1][i]));
                for (int k = 0; k < 3; k++) begin
                    prod2_reg[k][i] <= PB'(w1_reg[i]) * PB'(ax1_reg[k][i]);
                end
            end

            // stage 3
            mode3_reg <= mode2_reg;
            sr3_reg   <= sr2_reg;
            rs3_reg   <= rs2_reg;
            ww3_reg   <= WWB'(wsq2_reg[0]) + WWB'(wsq2_reg[1]) + WWB'(wsq2_reg[2]);
            uu3_reg   <= UUB'(usq2_reg[0]) + UUB'(usq2_reg[1]) + UUB'(usq2_reg[2]);
            for (int i = 0; i < 3; i++) begin
                w3_reg[i]  <= w2_reg[i];
                u3_reg[i]  <= u2_reg[i];
                sz3_reg[i] <= sz2_reg[i];
                p3_reg[i]  <= DB'(prod2_reg[i][0]) + DB'(prod2_reg[i][1])
                            + DB'(prod2_reg[i][2]);
            end

            // stage 4
            mode4_reg <= mode3_reg;
            hu4_reg   <= HUB'(sz3_reg[0]) * HUB'(uu3_reg);
            r2_4_reg  <= R2B'(rs3_reg) * R2B'(rs3_reg);
            srq4_reg  <= SRQB'(sr3_reg) * SRQB'(sr3_reg);
            s4_reg    <= p3_reg[1];
            ww4_reg   <= ww3_reg;
            uu4_reg   <= uu3_reg;
            pt4_reg   <= (sz3_reg[0] == '0) || (uu3_reg == '0);
            for (int i = 0; i < 3; i++) begin
                w4_reg[i]  <= w3_reg[i];
                ex4_reg[i] <= ex_next[i];
                uh4_reg[i] <= UHB'(u3_reg[i]) * UHB'(signed'({1'b0, sz3_reg[0]}));
            end

            // stage 5
            mode5_reg <= mode4_reg;
            srq5_reg  <= srq4_reg;
            end5_reg  <= cap_end;
            wwuu5_reg <= (WWB+UUB)'(ww4_reg) * (WWB+UUB)'(uu4_reg);
            r2uu5_reg <= (R2B+UUB)'(r2_4_reg) * (R2B+UUB)'(uu4_reg);
            ssq5_reg  <= unsigned'((2*DB)'(s4_reg) * (2*DB)'(s4_reg));
            near5_reg <= (R2B+WWB)'(ww4_reg) <= (R2B+WWB)'(r2_4_reg);
            pt5_reg   <= pt4_reg;
            r2_5_reg  <= r2_4_reg;
            for (int i = 0; i < 3; i++) begin
                exsq5_reg[i] <= (2*XB)'(ex4_reg[i]) * (2*XB)'(ex4_reg[i]);
                dd5_reg[i]   <= dd_next[i];
            end

            // stage 6
            mode6_reg   <= mode5_reg;
            boxhit6_reg <= ((2*XB+2)'(exsq5_reg[0]) + (2*XB+2)'(exsq5_reg[1])
                          + (2*XB+2)'(exsq5_reg[2]))
                          <= ((SRQB+2*AFB)'(srq5_reg) << (2*AFB));
            midhit6_reg <= (WWB+UUB+2*DB)'(wwuu5_reg)
                          <= (WWB+UUB+2*DB)'(r2uu5_reg) + (WWB+UUB+2*DB)'(ssq5_reg);
            end6_reg    <= end5_reg;
            pt6_reg     <= pt5_reg;
            near6_reg   <= near5_reg;
            r2_6_reg    <= r2_5_reg;
            for (int i = 0; i < 3; i++) begin
                dsq6_reg[i] <= unsigned'((2*DDB)'(dd5_reg[i]) * (2*DDB)'(dd5_reg[i]));
            end

            // stage 7: output register
            m_overlap_reg <= hit_next;
        end
    end

    // an accepted request enters the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[1])
        else $error("accepted request missing from first stage");

    // a held pipeline keeps its last stage
    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg[6]) && $stable(m_overlap_reg))
        else $error("pipeline moved during stall");

    // mode none never reports an overlap
    a_none_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[6] && mode6_reg == MODE_NONE |=> !m_overlap)
        else $error("overlap reported for mode none");

    // after reset nothing is presented
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
